[sv/icb_pkg.sv]
// ----------------------------------------------------------------------------
// icb_pkg: shared types and constants of the image content bounds block
// Field widths, register indexes, the pipeline payload structs and the
// reciprocal constants used for the padding divisions.
// ----------------------------------------------------------------------------
package icb_pkg;

	localparam int COLOR_W = 8;
	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int PAD_W   = 9;
	localparam int SQ_W    = 2 * COLOR_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int MAX_DIM = 4096;
	localparam int PAD_MIN = 2;

	// Division of a span below 8192 by 25: multiply by ceil(2^22 / 25), keep the top bits.
	localparam int DIV25_MULT_W = 18;
	localparam int DIV25_SHIFT  = 22;
	localparam logic [DIV25_MULT_W-1:0] DIV25_MULT = 18'd167773;
	// Division by 12 is a shift by two followed by a division by 3.
	localparam int DIV3_MULT_W = 12;
	localparam int DIV3_SHIFT  = 13;
	localparam logic [DIV3_MULT_W-1:0] DIV3_MULT = 12'd2731;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = DIM_W;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_THRESHOLD        = 3'd0,
		REG_BRIGHTNESS_MODE  = 3'd1,
		REG_BACKGROUND_RED   = 3'd2,
		REG_BACKGROUND_GREEN = 3'd3,
		REG_BACKGROUND_BLUE  = 3'd4,
		REG_IMAGE_WIDTH      = 3'd5,
		REG_IMAGE_HEIGHT     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [COLOR_W-1:0] threshold;
		logic               brightness_mode;
		logic [COLOR_W-1:0] background_red;
		logic [COLOR_W-1:0] background_green;
		logic [COLOR_W-1:0] background_blue;
		logic [DIM_W-1:0]   width_used;
		logic [DIM_W-1:0]   height_used;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               frame_end;
	} pixel_t;

	typedef struct packed {
		logic               content;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               frame_end;
	} hit_t;

	typedef struct packed {
		logic               seen;
		logic [COORD_W-1:0] low_x;
		logic [COORD_W-1:0] low_y;
		logic [COORD_W-1:0] high_x;
		logic [COORD_W-1:0] high_y;
	} bounds_t;

	typedef struct packed {
		logic [COORD_W-1:0] box_bottom;
		logic [COORD_W-1:0] box_right;
		logic [COORD_W-1:0] box_top;
		logic [COORD_W-1:0] box_left;
	} box_t;

	localparam bounds_t BOUNDS_CLEAR = '{
		seen:   1'b0,
		low_x:  {COORD_W{1'b1}},
		low_y:  {COORD_W{1'b1}},
		high_x: {COORD_W{1'b0}},
		high_y: {COORD_W{1'b0}}
	};

endpackage

[sv/image_content_bounds.sv]
// ----------------------------------------------------------------------------
// image_content_bounds: bounding box of the content in an RGB frame
// Classifies each pixel as content by peak channel or by distance from a
// background colour, tracks the content bounds over the frame and gives the
// padded, clipped box once per frame.
//
//   Channel   Direction  Transfer carries
//   s_axis    in         one pixel: colour, position, frame end on tlast
//   m_axis    out        one box per frame, after the frame end pixel
//   cfg       in         one register write, no handshake
//
// One pixel is accepted per cycle while the output side keeps up.
// A box is offered from the output register after its frame end pixel has
// passed the input register, two more classification stages, the bounds
// register and the padding stage.
// Reset clears all stage valids and the running bounds; settings return to
// their defaults.
// A stalled output box holds in the output register; the inner stages keep
// taking pixels until they are all full.
// ----------------------------------------------------------------------------
module image_content_bounds (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// red [7:0], green [15:8], blue [23:16], pos_x [35:24], pos_y [47:36]
	input  logic [47:0]                     s_axis_tdata,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// box_left [11:0], box_top [23:12], box_right [35:24], box_bottom [47:36]
	output logic [47:0]                     m_axis_tdata,
	input  logic                            cfg_wr_en,
	input  logic [icb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [icb_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

	icb_pkg::cfg_t    cfg;
	icb_pkg::pixel_t  in_pix;
	icb_pkg::hit_t    hit;
	icb_pkg::bounds_t bounds;
	icb_pkg::box_t    box;
	logic             hit_valid;
	logic             hit_ready;
	logic             bounds_valid;
	logic             bounds_ready;

	always_comb begin
		in_pix.red       = s_axis_tdata[7:0];
		in_pix.green     = s_axis_tdata[15:8];
		in_pix.blue      = s_axis_tdata[23:16];
		in_pix.pos_x     = s_axis_tdata[35:24];
		in_pix.pos_y     = s_axis_tdata[47:36];
		in_pix.frame_end = s_axis_tlast;
	end

	icb_cfg_regs u_cfg_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	icb_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pix    (in_pix),
		.out_valid (hit_valid),
		.out_ready (hit_ready),
		.out_hit   (hit)
	);

	icb_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (hit_valid),
		.in_ready   (hit_ready),
		.in_hit     (hit),
		.out_valid  (bounds_valid),
		.out_ready  (bounds_ready),
		.out_bounds (bounds)
	);

	icb_box u_box (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (bounds_valid),
		.in_ready  (bounds_ready),
		.in_bounds (bounds),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_box   (box)
	);

	assign m_axis_tdata = {box.box_bottom, box.box_right, box.box_top, box.box_left};

endmodule

[sv/icb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// icb_cfg_regs: configuration registers
// Holds the seven settings and presents them with the frame dimensions
// saturated to the supported range.
// ----------------------------------------------------------------------------
module icb_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [icb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [icb_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	output icb_pkg::cfg_t                   cfg
);

	logic [icb_pkg::COLOR_W-1:0] threshold_q;
	logic                        brightness_mode_q;
	logic [icb_pkg::COLOR_W-1:0] background_red_q;
	logic [icb_pkg::COLOR_W-1:0] background_green_q;
	logic [icb_pkg::COLOR_W-1:0] background_blue_q;
	logic [icb_pkg::DIM_W-1:0]   image_width_q;
	logic [icb_pkg::DIM_W-1:0]   image_height_q;
	icb_pkg::reg_idx_t           addr;

	assign addr = icb_pkg::reg_idx_t'(cfg_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q        <= 8'd30;
			brightness_mode_q  <= 1'b1;
			background_red_q   <= '0;
			background_green_q <= '0;
			background_blue_q  <= '0;
			image_width_q      <= icb_pkg::DIM_W'(icb_pkg::MAX_DIM);
			image_height_q     <= icb_pkg::DIM_W'(icb_pkg::MAX_DIM);
		end else if (cfg_wr_en) begin
			unique case (addr)
				icb_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg_wr_data[icb_pkg::COLOR_W-1:0];
				end
				icb_pkg::REG_BRIGHTNESS_MODE: begin
					brightness_mode_q <= cfg_wr_data[0];
				end
				icb_pkg::REG_BACKGROUND_RED: begin
					background_red_q <= cfg_wr_data[icb_pkg::COLOR_W-1:0];
				end
				icb_pkg::REG_BACKGROUND_GREEN: begin
					background_green_q <= cfg_wr_data[icb_pkg::COLOR_W-1:0];
				end
				icb_pkg::REG_BACKGROUND_BLUE: begin
					background_blue_q <= cfg_wr_data[icb_pkg::COLOR_W-1:0];
				end
				icb_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_wr_data;
				end
				icb_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.threshold        = threshold_q;
		cfg.brightness_mode  = brightness_mode_q;
		cfg.background_red   = background_red_q;
		cfg.background_green = background_green_q;
		cfg.background_blue  = background_blue_q;
		if (image_width_q == '0) begin
			cfg.width_used = icb_pkg::DIM_W'(1);
		end else if (image_width_q > icb_pkg::DIM_W'(icb_pkg::MAX_DIM)) begin
			cfg.width_used = icb_pkg::DIM_W'(icb_pkg::MAX_DIM);
		end else begin
			cfg.width_used = image_width_q;
		end
		if (image_height_q == '0) begin
			cfg.height_used = icb_pkg::DIM_W'(1);
		end else if (image_height_q > icb_pkg::DIM_W'(icb_pkg::MAX_DIM)) begin
			cfg.height_used = icb_pkg::DIM_W'(icb_pkg::MAX_DIM);
		end else begin
			cfg.height_used = image_height_q;
		end
	end

endmodule

[sv/icb_classify.sv]
// ----------------------------------------------------------------------------
// icb_classify: content test for each pixel
// Input register, then a stage for peak channel, squared differences and
// frame limits, then a stage for the distance sum and the threshold
// compare. Each stage holds its item only while the next one is full.
// ----------------------------------------------------------------------------
module icb_classify (
	input  logic             clk,
	input  logic             arst_n,
	input  icb_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  icb_pkg::pixel_t  in_pix,
	output logic             out_valid,
	input  logic             out_ready,
	output icb_pkg::hit_t    out_hit
);

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;

	icb_pkg::pixel_t pix_s1;

	logic                        bright_s2;
	logic                        in_frame_s2;
	logic [icb_pkg::SQ_W-1:0]    sq_red_s2;
	logic [icb_pkg::SQ_W-1:0]    sq_green_s2;
	logic [icb_pkg::SQ_W-1:0]    sq_blue_s2;
	logic [icb_pkg::SQ_W-1:0]    thr_sq_s2;
	logic [icb_pkg::COORD_W-1:0] pos_x_s2;
	logic [icb_pkg::COORD_W-1:0] pos_y_s2;
	logic                        frame_end_s2;

	icb_pkg::hit_t hit_s3;

	logic [icb_pkg::COLOR_W-1:0] peak;
	logic [icb_pkg::COLOR_W-1:0] diff_red;
	logic [icb_pkg::COLOR_W-1:0] diff_green;
	logic [icb_pkg::COLOR_W-1:0] diff_blue;
	logic                        in_frame;
	logic [icb_pkg::SUM_W-1:0]   dist_sum;
	logic                        content;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		peak = (pix_s1.red > pix_s1.green) ? pix_s1.red : pix_s1.green;
		if (pix_s1.blue > peak) begin
			peak = pix_s1.blue;
		end
		diff_red = (pix_s1.red > cfg.background_red) ?
			pix_s1.red - cfg.background_red : cfg.background_red - pix_s1.red;
		diff_green = (pix_s1.green > cfg.background_green) ?
			pix_s1.green - cfg.background_green : cfg.background_green - pix_s1.green;
		diff_blue = (pix_s1.blue > cfg.background_blue) ?
			pix_s1.blue - cfg.background_blue : cfg.background_blue - pix_s1.blue;
		in_frame = ({1'b0, pix_s1.pos_x} < cfg.width_used) &&
			({1'b0, pix_s1.pos_y} < cfg.height_used);
	end

	always_comb begin
		dist_sum = icb_pkg::SUM_W'(sq_red_s2) + icb_pkg::SUM_W'(sq_green_s2) +
			icb_pkg::SUM_W'(sq_blue_s2);
		content = in_frame_s2 &&
			(cfg.brightness_mode ? bright_s2 : (dist_sum > icb_pkg::SUM_W'(thr_sq_s2)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pix_s1 <= in_pix;
		end
		if (rdy_s2 && v_s1) begin
			bright_s2    <= peak > cfg.threshold;
			in_frame_s2  <= in_frame;
			sq_red_s2    <= icb_pkg::SQ_W'(diff_red) * icb_pkg::SQ_W'(diff_red);
			sq_green_s2  <= icb_pkg::SQ_W'(diff_green) * icb_pkg::SQ_W'(diff_green);
			sq_blue_s2   <= icb_pkg::SQ_W'(diff_blue) * icb_pkg::SQ_W'(diff_blue);
			thr_sq_s2    <= icb_pkg::SQ_W'(cfg.threshold) * icb_pkg::SQ_W'(cfg.threshold);
			pos_x_s2     <= pix_s1.pos_x;
			pos_y_s2     <= pix_s1.pos_y;
			frame_end_s2 <= pix_s1.frame_end;
		end
		if (rdy_s3 && v_s2) begin
			hit_s3.content   <= content;
			hit_s3.pos_x     <= pos_x_s2;
			hit_s3.pos_y     <= pos_y_s2;
			hit_s3.frame_end <= frame_end_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_hit   = hit_s3;

endmodule

[sv/icb_track.sv]
// ----------------------------------------------------------------------------
// icb_track: running bounds of the content pixels
// Updates the minimum and maximum column and row on every content pixel.
// On the frame end pixel the updated bounds move to a holding register and
// the running bounds are cleared for the next frame.
// ----------------------------------------------------------------------------
module icb_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  icb_pkg::hit_t     in_hit,
	output logic              out_valid,
	input  logic              out_ready,
	output icb_pkg::bounds_t  out_bounds
);

	icb_pkg::bounds_t acc_q;
	icb_pkg::bounds_t nxt;
	icb_pkg::bounds_t bnd_s4;
	logic             v_s4;
	logic             rdy_s4;
	logic             take;

	assign rdy_s4   = !v_s4 || out_ready;
	assign in_ready = !in_hit.frame_end || rdy_s4;
	assign take     = in_valid && in_ready;

	always_comb begin
		nxt = acc_q;
		if (in_hit.content) begin
			if (!acc_q.seen) begin
				nxt.seen   = 1'b1;
				nxt.low_x  = in_hit.pos_x;
				nxt.high_x = in_hit.pos_x;
				nxt.low_y  = in_hit.pos_y;
				nxt.high_y = in_hit.pos_y;
			end else begin
				if (in_hit.pos_x < acc_q.low_x) begin
					nxt.low_x = in_hit.pos_x;
				end
				if (in_hit.pos_x > acc_q.high_x) begin
					nxt.high_x = in_hit.pos_x;
				end
				if (in_hit.pos_y < acc_q.low_y) begin
					nxt.low_y = in_hit.pos_y;
				end
				if (in_hit.pos_y > acc_q.high_y) begin
					nxt.high_y = in_hit.pos_y;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= icb_pkg::BOUNDS_CLEAR;
			v_s4  <= 1'b0;
		end else begin
			if (take) begin
				acc_q <= in_hit.frame_end ? icb_pkg::BOUNDS_CLEAR : nxt;
			end
			if (rdy_s4) begin
				v_s4 <= take && in_hit.frame_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_hit.frame_end) begin
			bnd_s4 <= nxt;
		end
	end

	assign out_valid  = v_s4;
	assign out_bounds = bnd_s4;

endmodule

[sv/icb_box.sv]
// ----------------------------------------------------------------------------
// icb_box: padding and clipping of the frame bounds
// One stage works out the paddings by reciprocal multiplication, the output
// stage applies them, clips to the frame and selects the whole frame when
// no content was seen.
// ----------------------------------------------------------------------------
module icb_box (
	input  logic              clk,
	input  logic              arst_n,
	input  icb_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  icb_pkg::bounds_t  in_bounds,
	output logic              out_valid,
	input  logic              out_ready,
	output icb_pkg::box_t     out_box
);

	localparam int PROD_X_W = icb_pkg::DIM_W + icb_pkg::DIV25_MULT_W;
	localparam int QUART_W  = icb_pkg::DIM_W - 2;
	localparam int PROD_Y_W = QUART_W + icb_pkg::DIV3_MULT_W;

	logic v_s5;
	logic rdy_s5;
	logic rdy_out;
	logic out_valid_q;

	icb_pkg::bounds_t          bnd_s5;
	logic [icb_pkg::PAD_W-1:0] pad_x_s5;
	logic [icb_pkg::PAD_W-1:0] pad_y_s5;
	icb_pkg::box_t             box_q;

	logic [icb_pkg::DIM_W-1:0]   span_x;
	logic [icb_pkg::DIM_W-1:0]   span_y;
	logic [PROD_X_W-1:0]         prod_x;
	logic [PROD_Y_W-1:0]         prod_y;
	logic [icb_pkg::PAD_W-1:0]   quot_x;
	logic [icb_pkg::PAD_W-1:0]   quot_y;
	logic [icb_pkg::PAD_W-1:0]   pad_x;
	logic [icb_pkg::PAD_W-1:0]   pad_y;
	logic [icb_pkg::COORD_W-1:0] pad_x_ext;
	logic [icb_pkg::COORD_W-1:0] pad_y_ext;
	logic [icb_pkg::COORD_W-1:0] last_col;
	logic [icb_pkg::COORD_W-1:0] last_row;
	logic [icb_pkg::DIM_W-1:0]   right_sum;
	logic [icb_pkg::DIM_W-1:0]   bottom_sum;
	icb_pkg::box_t               box_d;

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s5   = !v_s5 || rdy_out;
	assign in_ready = rdy_s5;

	// The quotients stay exact for every span up to the largest frame.
	always_comb begin
		span_x = {1'b0, in_bounds.high_x} - {1'b0, in_bounds.low_x} + icb_pkg::DIM_W'(1);
		span_y = {1'b0, in_bounds.high_y} - {1'b0, in_bounds.low_y} + icb_pkg::DIM_W'(1);
		prod_x = PROD_X_W'(span_x) * PROD_X_W'(icb_pkg::DIV25_MULT);
		prod_y = PROD_Y_W'(span_y[icb_pkg::DIM_W-1:2]) * PROD_Y_W'(icb_pkg::DIV3_MULT);
		quot_x = prod_x[icb_pkg::DIV25_SHIFT +: icb_pkg::PAD_W];
		quot_y = prod_y[icb_pkg::DIV3_SHIFT +: icb_pkg::PAD_W];
		pad_x  = (quot_x < icb_pkg::PAD_W'(icb_pkg::PAD_MIN)) ?
			icb_pkg::PAD_W'(icb_pkg::PAD_MIN) : quot_x;
		pad_y  = (quot_y < icb_pkg::PAD_W'(icb_pkg::PAD_MIN)) ?
			icb_pkg::PAD_W'(icb_pkg::PAD_MIN) : quot_y;
	end

	always_comb begin
		pad_x_ext  = icb_pkg::COORD_W'(pad_x_s5);
		pad_y_ext  = icb_pkg::COORD_W'(pad_y_s5);
		last_col   = icb_pkg::COORD_W'(cfg.width_used - icb_pkg::DIM_W'(1));
		last_row   = icb_pkg::COORD_W'(cfg.height_used - icb_pkg::DIM_W'(1));
		right_sum  = {1'b0, bnd_s5.high_x} + {1'b0, pad_x_ext};
		bottom_sum = {1'b0, bnd_s5.high_y} + {1'b0, pad_y_ext};
		if (bnd_s5.seen) begin
			box_d.box_left = (bnd_s5.low_x >= pad_x_ext) ? bnd_s5.low_x - pad_x_ext : '0;
			box_d.box_top  = (bnd_s5.low_y >= pad_y_ext) ? bnd_s5.low_y - pad_y_ext : '0;
			box_d.box_right = (right_sum > {1'b0, last_col}) ?
				last_col : right_sum[icb_pkg::COORD_W-1:0];
			box_d.box_bottom = (bottom_sum > {1'b0, last_row}) ?
				last_row : bottom_sum[icb_pkg::COORD_W-1:0];
		end else begin
			box_d.box_left   = '0;
			box_d.box_top    = '0;
			box_d.box_right  = last_col;
			box_d.box_bottom = last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s5) begin
				v_s5 <= in_valid;
			end
			if (rdy_out) begin
				out_valid_q <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			bnd_s5   <= in_bounds;
			pad_x_s5 <= pad_x;
			pad_y_s5 <= pad_y;
		end
		if (rdy_out && v_s5) begin
			box_q <= box_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_box   = box_q;

endmodule

[sv/icb_checker.sv]
// ----------------------------------------------------------------------------
// icb_checker: port-level checks of image_content_bounds
// Watches the stream ports and flags a moving stalled box, an inverted box,
// a stalled input with an empty output register, or a box out of reset.
// ----------------------------------------------------------------------------
module icb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [47:0]  m_axis_tdata
);

	a_box_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("Stalled box changed before its transfer.");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[11:0] <= m_axis_tdata[35:24]) &&
			(m_axis_tdata[23:12] <= m_axis_tdata[47:36]))
		else $error("Box has its left past its right or its top past its bottom.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("Input stalled while the output register is empty.");

	a_quiet_after_reset: assert property (@(posedge clk)
		arst_n && $past(!arst_n) |-> !m_axis_tvalid)
		else $error("Box offered straight out of reset.");

endmodule

bind image_content_bounds icb_checker u_icb_checker (.*);

[dv/image_content_bounds_test.sv]
// ----------------------------------------------------------------------------
// image_content_bounds_test: self-checking bench for the content bounds block
// Drives pixel streams through the block, models the content test and the
// padded, clipped box in the bench itself, and checks every box that comes
// out. A short directed table covers the threshold edges, both content modes,
// pixels outside the frame, saturated dimensions and an unused register
// index. Random phases then change every setting and the amount of idling on
// both sides. One phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module image_content_bounds_test;

	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 20;
	localparam logic [icb_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		bit                  is_write;
		logic [2:0]          addr;
		logic [12:0]         data;
		logic [7:0]          r;
		logic [7:0]          g;
		logic [7:0]          b;
		logic [11:0]         x;
		logic [11:0]         y;
		logic                fin;
		bit                  typed;
		icb_pkg::box_t       want;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [47:0]                    s_axis_tdata = '0;
	logic                           s_axis_tlast = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [47:0]                    m_axis_tdata;
	logic                           cfg_wr_en = 1'b0;
	logic [icb_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [icb_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

	// Settings and running bounds as the block should hold them.
	logic [7:0]  thr = 8'd30;
	logic        peak_mode = 1'b1;
	logic [7:0]  bg_r = '0;
	logic [7:0]  bg_g = '0;
	logic [7:0]  bg_b = '0;
	logic [12:0] width_reg = 13'd4096;
	logic [12:0] height_reg = 13'd4096;
	bit          seen = 1'b0;
	int          lo_x = 4095;
	int          lo_y = 4095;
	int          hi_x = 0;
	int          hi_y = 0;

	icb_pkg::box_t pending_boxes[$];
	int            fail_count = 0;
	idle_mode_t    idle_mode = IDLE_NONE;
	bit            hold_request = 1'b0;
	int            hold_left = 0;

	image_content_bounds dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int dim_limit(int v);
		if (v < 1) return 1;
		if (v > icb_pkg::MAX_DIM) return icb_pkg::MAX_DIM;
		return v;
	endfunction

	function automatic logic [7:0] near_level(logic [7:0] base);
		int v;
		v = int'(base) + int'($urandom_range(12)) - 6;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	function automatic stim_row_t reg_step(logic [2:0] addr, logic [12:0] data);
		stim_row_t s;
		s.is_write = 1'b1;
		s.addr = addr;
		s.data = data;
		s.typed = 1'b0;
		return s;
	endfunction

	function automatic stim_row_t pixel_step(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [11:0] x, logic [11:0] y, logic fin);
		stim_row_t s;
		s.is_write = 1'b0;
		s.r = r;
		s.g = g;
		s.b = b;
		s.x = x;
		s.y = y;
		s.fin = fin;
		s.typed = 1'b0;
		return s;
	endfunction

	function automatic stim_row_t boxed_step(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [11:0] x, logic [11:0] y, logic [11:0] lft, logic [11:0] tp,
			logic [11:0] rgt, logic [11:0] btm);
		stim_row_t s;
		s = pixel_step(r, g, b, x, y, 1'b1);
		s.typed = 1'b1;
		s.want.box_left = lft;
		s.want.box_top = tp;
		s.want.box_right = rgt;
		s.want.box_bottom = btm;
		return s;
	endfunction

	task automatic track_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [11:0] x, input logic [11:0] y, input logic fin,
			output bit has_box, output icb_pkg::box_t box);
		int w;
		int h;
		int d;
		int dist_sq;
		int px;
		int py;
		int lft;
		int tp;
		int rgt;
		int btm;
		bit hit;
		w = dim_limit(int'(width_reg));
		h = dim_limit(int'(height_reg));
		if (peak_mode) begin
			hit = (r > thr) || (g > thr) || (b > thr);
		end else begin
			d = int'(r) - int'(bg_r);
			dist_sq = d * d;
			d = int'(g) - int'(bg_g);
			dist_sq += d * d;
			d = int'(b) - int'(bg_b);
			dist_sq += d * d;
			hit = dist_sq > int'(thr) * int'(thr);
		end
		if (int'(x) >= w || int'(y) >= h)
			hit = 1'b0;
		if (hit) begin
			if (!seen) begin
				lo_x = int'(x);
				hi_x = int'(x);
				lo_y = int'(y);
				hi_y = int'(y);
				seen = 1'b1;
			end else begin
				if (int'(x) < lo_x) lo_x = int'(x);
				if (int'(x) > hi_x) hi_x = int'(x);
				if (int'(y) < lo_y) lo_y = int'(y);
				if (int'(y) > hi_y) hi_y = int'(y);
			end
		end
		has_box = fin;
		box = '0;
		if (fin) begin
			lft = 0;
			tp = 0;
			rgt = w - 1;
			btm = h - 1;
			if (seen) begin
				px = (hi_x - lo_x + 1) / 25;
				py = (hi_y - lo_y + 1) / 12;
				if (px < icb_pkg::PAD_MIN) px = icb_pkg::PAD_MIN;
				if (py < icb_pkg::PAD_MIN) py = icb_pkg::PAD_MIN;
				lft = (lo_x >= px) ? lo_x - px : 0;
				tp = (lo_y >= py) ? lo_y - py : 0;
				rgt = (hi_x + px > w - 1) ? w - 1 : hi_x + px;
				btm = (hi_y + py > h - 1) ? h - 1 : hi_y + py;
			end
			box.box_left = lft[11:0];
			box.box_top = tp[11:0];
			box.box_right = rgt[11:0];
			box.box_bottom = btm[11:0];
			seen = 1'b0;
			lo_x = 4095;
			lo_y = 4095;
			hi_x = 0;
			hi_y = 0;
		end
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [12:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wr_data <= data;
		case (addr)
			icb_pkg::REG_THRESHOLD:        thr = data[7:0];
			icb_pkg::REG_BRIGHTNESS_MODE:  peak_mode = data[0];
			icb_pkg::REG_BACKGROUND_RED:   bg_r = data[7:0];
			icb_pkg::REG_BACKGROUND_GREEN: bg_g = data[7:0];
			icb_pkg::REG_BACKGROUND_BLUE:  bg_b = data[7:0];
			icb_pkg::REG_IMAGE_WIDTH:      width_reg = data;
			icb_pkg::REG_IMAGE_HEIGHT:     height_reg = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [11:0] x, input logic [11:0] y, input logic fin,
			input bit typed, input icb_pkg::box_t want);
		bit has_box;
		icb_pkg::box_t box;
		while ((idle_mode == IDLE_SEND && $urandom_range(99) < 57) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 37)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x, b, g, r};
		s_axis_tlast <= fin;
		forever begin
			@(posedge clk);
			if (s_axis_tready) break;
		end
		track_pixel(r, g, b, x, y, fin, has_box, box);
		if (has_box)
			pending_boxes = {pending_boxes, typed ? want : box};
		@(negedge clk);
	endtask

	// Stops offering pixels and lets the pipeline empty out completely.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_boxes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 57) ||
					(idle_mode == IDLE_BOTH && $urandom_range(99) < 37));
		end
	end

	always @(posedge clk) begin
		icb_pkg::box_t got;
		icb_pkg::box_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = icb_pkg::box_t'(m_axis_tdata);
			if (pending_boxes.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected box transfer: %0d %0d %0d %0d", got.box_left,
							got.box_top, got.box_right, got.box_bottom);
				fail_count++;
			end else begin
				want = pending_boxes.pop_front();
				if (got.box_left !== want.box_left || got.box_top !== want.box_top ||
						got.box_right !== want.box_right ||
						got.box_bottom !== want.box_bottom) begin
					if (fail_count < 10)
						$display("box mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
								want.box_left, want.box_top, want.box_right,
								want.box_bottom, got.box_left, got.box_top,
								got.box_right, got.box_bottom);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("image_content_bounds verification failed");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		bit in_cfg;
		int phase;
		int items_sent;
		int budget;
		int n;
		int flen;
		int wu;
		int hu;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [11:0] x;
		logic [11:0] y;
		logic [12:0] dim;

		rows = {rows, boxed_step(8'd0, 8'd0, 8'd0, 12'd0, 12'd0,
				12'd0, 12'd0, 12'd4095, 12'd4095)};
		rows = {rows, boxed_step(8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095,
				12'd4093, 12'd4093, 12'd4095, 12'd4095)};
		rows = {rows, pixel_step(8'd31, 8'd0, 8'd0, 12'd0, 12'd0, 1'b0)};
		rows = {rows, pixel_step(8'd30, 8'd30, 8'd30, 12'd100, 12'd100, 1'b0)};
		rows = {rows, pixel_step(8'd0, 8'd255, 8'd0, 12'd4095, 12'd0, 1'b0)};
		rows = {rows, pixel_step(8'd0, 8'd0, 8'd31, 12'd0, 12'd4095, 1'b1)};
		rows = {rows, reg_step(icb_pkg::REG_IMAGE_WIDTH, 13'd0)};
		rows = {rows, reg_step(icb_pkg::REG_IMAGE_HEIGHT, 13'd8191)};
		rows = {rows, boxed_step(8'd255, 8'd0, 8'd0, 12'd1, 12'd5,
				12'd0, 12'd0, 12'd0, 12'd4095)};
		rows = {rows, pixel_step(8'd255, 8'd0, 8'd0, 12'd0, 12'd7, 1'b1)};
		rows = {rows, reg_step(icb_pkg::REG_IMAGE_WIDTH, 13'd100)};
		rows = {rows, reg_step(icb_pkg::REG_IMAGE_HEIGHT, 13'd50)};
		rows = {rows, reg_step(icb_pkg::REG_BRIGHTNESS_MODE, 13'd0)};
		rows = {rows, reg_step(icb_pkg::REG_BACKGROUND_RED, 13'd255)};
		rows = {rows, reg_step(icb_pkg::REG_BACKGROUND_GREEN, 13'd128)};
		rows = {rows, reg_step(icb_pkg::REG_BACKGROUND_BLUE, 13'd1)};
		rows = {rows, reg_step(icb_pkg::REG_THRESHOLD, 13'd255)};
		rows = {rows, pixel_step(8'd0, 8'd0, 8'd255, 12'd99, 12'd49, 1'b0)};
		rows = {rows, pixel_step(8'd255, 8'd128, 8'd1, 12'd0, 12'd0, 1'b1)};
		rows = {rows, reg_step(icb_pkg::REG_THRESHOLD, 13'd3)};
		rows = {rows, reg_step(REG_UNUSED, 13'd8191)};
		rows = {rows, pixel_step(8'd252, 8'd128, 8'd1, 12'd5, 12'd5, 1'b0)};
		rows = {rows, boxed_step(8'd254, 8'd128, 8'd1, 12'd100, 12'd10,
				12'd0, 12'd0, 12'd99, 12'd49)};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		in_cfg = 1'b0;
		foreach (rows[i]) begin
			row = rows[i];
			if (row.is_write) begin
				if (!in_cfg) begin
					drain();
					in_cfg = 1'b1;
				end
				write_reg(row.addr, row.data);
			end else begin
				if (in_cfg) begin
					cfg_wr_en <= 1'b0;
					in_cfg = 1'b0;
				end
				send_pixel(row.r, row.g, row.b, row.x, row.y, row.fin, row.typed, row.want);
			end
		end

		phase = 0;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			idle_mode = idle_mode_t'(phase % 4);
			drain();
			write_reg(icb_pkg::REG_THRESHOLD, (phase == 0) ? 13'd0 :
					(phase == 1) ? 13'd255 : 13'($urandom_range(255)));
			write_reg(icb_pkg::REG_BRIGHTNESS_MODE, 13'($urandom_range(1)));
			write_reg(icb_pkg::REG_BACKGROUND_RED, 13'($urandom_range(255)));
			write_reg(icb_pkg::REG_BACKGROUND_GREEN, 13'($urandom_range(255)));
			write_reg(icb_pkg::REG_BACKGROUND_BLUE, 13'($urandom_range(255)));
			for (int k = 0; k < 2; k++) begin
				case ($urandom_range(9))
					0: dim = 13'd0;
					1: dim = 13'd1;
					2: dim = 13'd4096;
					3: dim = 13'($urandom_range(8191, 4097));
					4, 5, 6: dim = 13'($urandom_range(64, 2));
					default: dim = 13'($urandom_range(4096, 1));
				endcase
				write_reg((k == 0) ? icb_pkg::REG_IMAGE_WIDTH : icb_pkg::REG_IMAGE_HEIGHT,
						dim);
			end
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, 13'($urandom_range(8191)));
			cfg_wr_en <= 1'b0;

			// Short frames while the output is held off, so the block fills up.
			if (phase == 2)
				hold_request = 1'b1;
			wu = dim_limit(int'(width_reg));
			hu = dim_limit(int'(height_reg));
			budget = (phase == 2) ? 150 : $urandom_range(140, 60);
			n = 0;
			while (n < budget) begin
				if (phase == 2)
					flen = $urandom_range(3, 1);
				else
					flen = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
				for (int k = 0; k < flen; k++) begin
					if ($urandom_range(9) < 5) begin
						r = 8'($urandom_range(255));
						g = 8'($urandom_range(255));
						b = 8'($urandom_range(255));
					end else if (peak_mode) begin
						r = 8'($urandom_range(thr));
						g = 8'($urandom_range(thr));
						b = 8'($urandom_range(thr));
					end else begin
						r = near_level(bg_r);
						g = near_level(bg_g);
						b = near_level(bg_b);
					end
					x = ($urandom_range(99) < 85) ? 12'($urandom_range(wu - 1)) :
							12'($urandom_range(4095));
					y = ($urandom_range(99) < 85) ? 12'($urandom_range(hu - 1)) :
							12'($urandom_range(4095));
					send_pixel(r, g, b, x, y, k == flen - 1, 1'b0, '0);
					n++;
					items_sent++;
				end
			end
			phase++;
		end

		drain();
		if (fail_count == 0)
			$display("image_content_bounds verification clean");
		else
			$display("image_content_bounds verification failed");
		$finish;
	end

endmodule
